>>> rtl/trv_pkg.sv
// Shared types and constants of the trail ribbon vertex expander.
// Depends on nothing; trv_if and the top level import it.
`default_nettype none

package trv_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_POINTS = 1024;
    localparam int CNT_W      = 11;
    localparam int TEXV_W     = FRAC_BITS + 1;
    localparam int CFG_ADDR_W = 3;

    typedef enum logic [1:0] {
        MODE_AXIS      = 2'd0,
        MODE_BILLBOARD = 2'd1,
        MODE_STRIP     = 2'd2,
        MODE_UNUSED    = 2'd3
    } trail_mode_t;

    localparam logic [CFG_ADDR_W-1:0] REG_TRAIL_MODE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STRIP_WIDTH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CAMERA_X    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CAMERA_Y    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CAMERA_Z    = 3'd4;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] side_x;
        logic signed [31:0] side_y;
        logic signed [31:0] side_z;
        logic [CNT_W-1:0]   point_count;
    } point_t;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic               tex_u;
        logic [TEXV_W-1:0]  tex_v;
        logic               run_last;
        logic               trail_end;
    } vert_t;

endpackage

`default_nettype wire

>>> rtl/trv_if.sv
// Request channel interfaces of the trail ribbon vertex expander.
// Depends on trv_pkg for the payload types.
`default_nettype none

interface trv_point_if;
    import trv_pkg::*;
    logic   valid;
    logic   ready;
    point_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface trv_vert_if;
    import trv_pkg::*;
    logic  valid;
    logic  ready;
    vert_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface trv_cfg_if;
    import trv_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [31:0]           wdata;
    modport source(output valid, output addr, output wdata, input ready);
    modport sink(input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/trail_ribbon_vertex_expander_unit.sv
// Trail ribbon vertex expander: turns trail control points into triangle-strip vertices.
// Depends on trv_pkg, the trv_if interfaces, trv_div and trv_isqrt.
//
// The pnt channel takes one control point per request; the vtx channel returns zero to
// four vertex requests for it, the last one marked by run_last, the final vertex of a
// trail also by trail_end. The cfg channel writes the mode, width and camera registers;
// it is always ready, and the user must write it only while the block is idle; the
// block itself does not enforce this. One point is worked on at a time, and pnt.ready
// is low until its last vertex has been placed in the output register. A sequencer
// drives one shared multiplier, a 64-step divider and a 32-step square root. The
// second billboard point also emits the first point's pair. The output register lets
// the next point be accepted while the last vertex still waits; a stalled receiver
// holds the sequencer at its next vertex. Reset clears the point index and previous
// position and loads the register defaults: axis mode, width 1.0, camera at the origin.
`default_nettype none

module trail_ribbon_vertex_expander_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    trv_cfg_if.sink   cfg,
    trv_point_if.sink pnt,
    trv_vert_if.source vtx
);
    import trv_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_DVS   = 13'b0000000000010,
        S_DVW   = 13'b0000000000100,
        S_DIRV  = 13'b0000000001000,
        S_SHRD  = 13'b0000000010000,
        S_SHRV  = 13'b0000000100000,
        S_CROSS = 13'b0000001000000,
        S_CMAG  = 13'b0000010000000,
        S_SHRC  = 13'b0000100000000,
        S_SQ    = 13'b0001000000000,
        S_RTS   = 13'b0010000000000,
        S_RTW   = 13'b0100000000000,
        S_OFFM  = 13'b1000000000000
    } state_t;

    // Vertices are emitted from a state of their own, kept outside the enum above.
    logic emit_reg;

    state_t              state_reg, state_next;
    trail_mode_t         mode_reg;
    logic [30:0]         width_reg;
    logic signed [31:0]  cam_reg [0:2];
    logic [CNT_W-1:0]    idx_reg;
    logic signed [31:0]  prev_reg [0:2];
    logic                tex_phase_reg;
    logic                pass_reg;
    logic [2:0]          step_reg;
    logic                out_valid_reg;
    vert_t               out_reg;

    logic [CNT_W-1:0]    i_reg, n_reg;
    logic signed [31:0]  pos_reg [0:2];
    logic signed [31:0]  pr_reg [0:2];
    logic [TEXV_W-1:0]   tv_reg;
    logic [32:0]         dm_reg [0:2];
    logic [32:0]         vm_reg [0:2];
    logic [2:0]          ds_reg, vs_reg;
    logic signed [62:0]  c_reg [0:2];
    logic [61:0]         cm_reg [0:2];
    logic [2:0]          cs_reg;
    logic [31:0]         am_reg [0:2];
    logic [2:0]          as_reg;
    logic [63:0]         sum_reg;
    logic [31:0]         len_reg;
    logic [31:0]         off_reg [0:2];
    logic [63:0]         prod_reg;
    logic                psgn_reg;
    logic [1:0]          pdst_reg;

    logic                acc;
    logic [CNT_W-1:0]    n_c, i_c, need_c;
    logic                short_c, none_c;
    logic [CNT_W:0]      i_inc;
    logic [1:0]          k;
    logic [31:0]         am_sel;
    logic [31:0]         mul_a, mul_b;
    logic [1:0]          cd, cv, cdst;
    logic                cneg;
    logic [CNT_W-1:0]    den_t;
    logic [63:0]         div_num;
    logic [33:0]         div_den;
    logic                div_start, div_done;
    logic [31:0]         quo;
    logic                rt_done;
    logic [31:0]         root;
    logic                any_d, any_v, any_c;
    logic                bb_first, emit_go, emit_last;
    logic signed [31:0]  base [0:2];
    logic signed [31:0]  vout [0:2];
    logic                strip_m;

    function automatic logic signed [31:0] sat_add(logic signed [31:0] b, logic [31:0] m,
                                                   logic neg);
        logic signed [33:0] s;
        s = neg ? ({{2{b[31]}}, b} - {2'b00, m}) : ({{2{b[31]}}, b} + {2'b00, m});
        if (s > 34'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (s < -34'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return s[31:0];
    endfunction

    function automatic logic [32:0] mag33(logic signed [32:0] v);
        return v[32] ? (33'd0 - v) : v;
    endfunction

    function automatic logic [31:0] mag32(logic signed [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    assign cfg.ready = 1'b1;
    assign pnt.ready = (state_reg == S_IDLE) && !emit_reg;
    assign acc       = pnt.valid && pnt.ready;
    assign strip_m   = (mode_reg == MODE_STRIP);

    always_comb
    begin
        n_c     = (pnt.data.point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                              : pnt.data.point_count;
        need_c  = strip_m ? CNT_W'(4) : CNT_W'(2);
        short_c = (mode_reg == MODE_UNUSED) || (n_c < need_c);
        i_c     = (idx_reg >= n_c) ? '0 : idx_reg;
        i_inc   = {1'b0, i_c} + (CNT_W+1)'(1);
        none_c  = short_c || ((mode_reg == MODE_BILLBOARD) && (i_c == '0));
    end

    assign k = step_reg[1:0];

    always_comb
    begin
        case (k)
            2'd0:    am_sel = am_reg[0];
            2'd1:    am_sel = am_reg[1];
            2'd2:    am_sel = am_reg[2];
            default: am_sel = '0;
        endcase
    end

    always_comb
    begin
        case (step_reg)
            3'd0:    begin cd = 2'd1; cv = 2'd2; cdst = 2'd0; cneg = 1'b0; end
            3'd1:    begin cd = 2'd2; cv = 2'd1; cdst = 2'd0; cneg = 1'b1; end
            3'd2:    begin cd = 2'd2; cv = 2'd0; cdst = 2'd1; cneg = 1'b0; end
            3'd3:    begin cd = 2'd0; cv = 2'd2; cdst = 2'd1; cneg = 1'b1; end
            3'd4:    begin cd = 2'd0; cv = 2'd1; cdst = 2'd2; cneg = 1'b0; end
            3'd5:    begin cd = 2'd1; cv = 2'd0; cdst = 2'd2; cneg = 1'b1; end
            default: begin cd = 2'd0; cv = 2'd0; cdst = 2'd0; cneg = 1'b0; end
        endcase
    end

    always_comb
    begin
        if (state_reg == S_CROSS)
        begin
            mul_a = dm_reg[cd][31:0];
            mul_b = vm_reg[cv][31:0];
        end
        else if (state_reg == S_OFFM)
        begin
            mul_a = am_sel;
            mul_b = {1'b0, width_reg};
        end
        else
        begin
            mul_a = am_sel;
            mul_b = am_sel;
        end
    end

    always_comb
    begin
        den_t = strip_m ? n_reg : (n_reg - CNT_W'(1));
        if (tex_phase_reg)
        begin
            div_num = {{(64-CNT_W-FRAC_BITS-1){1'b0}}, i_reg, {(FRAC_BITS+1){1'b0}}}
                      + {{(64-CNT_W){1'b0}}, den_t};
            div_den = {{(33-CNT_W){1'b0}}, den_t, 1'b0};
        end
        else
        begin
            div_num = prod_reg + {32'd0, len_reg};
            div_den = {1'b0, len_reg, 1'b0};
        end
    end

    assign div_start = (state_reg == S_DVS);

    trv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    trv_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_RTS),
        .x     (sum_reg),
        .done  (rt_done),
        .root  (root)
    );

    assign any_d = (|dm_reg[0][32:30]) || (|dm_reg[1][32:30]) || (|dm_reg[2][32:30]);
    assign any_v = (|vm_reg[0][32:30]) || (|vm_reg[1][32:30]) || (|vm_reg[2][32:30]);
    assign any_c = (|cm_reg[0][61:31]) || (|cm_reg[1][61:31]) || (|cm_reg[2][61:31]);

    assign bb_first = (mode_reg == MODE_BILLBOARD) && (i_reg == CNT_W'(1)) && !pass_reg;
    assign emit_go  = emit_reg && (!out_valid_reg || vtx.ready);
    assign emit_last = strip_m || ((step_reg[0] == 1'b1) && !bb_first);

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            base[j] = bb_first ? pr_reg[j] : pos_reg[j];
            vout[j] = strip_m ? base[j]
                              : sat_add(base[j], off_reg[j], as_reg[j] ^ step_reg[0]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc && !none_c)
                    state_next = S_DVS;
            end
            S_DVS:
            begin
                state_next = S_DVW;
            end
            S_DVW:
            begin
                if (div_done)
                begin
                    if (tex_phase_reg)
                    begin
                        if (strip_m)
                            state_next = S_IDLE;
                        else if (mode_reg == MODE_AXIS)
                            state_next = S_SQ;
                        else
                            state_next = S_DIRV;
                    end
                    else if (step_reg == 3'd2)
                        state_next = S_IDLE;
                    else
                        state_next = S_OFFM;
                end
            end
            S_DIRV:  state_next = S_SHRD;
            S_SHRD:  state_next = any_d ? S_SHRD : S_SHRV;
            S_SHRV:  state_next = any_v ? S_SHRV : S_CROSS;
            S_CROSS: state_next = (step_reg == 3'd6) ? S_CMAG : S_CROSS;
            S_CMAG:  state_next = S_SHRC;
            S_SHRC:  state_next = any_c ? S_SHRC : S_SQ;
            S_SQ:    state_next = (step_reg == 3'd3) ? S_RTS : S_SQ;
            S_RTS:   state_next = S_RTW;
            S_RTW:
            begin
                if (rt_done)
                    state_next = (root == '0) ? S_IDLE : S_OFFM;
            end
            S_OFFM:  state_next = S_DVS;
            default: state_next = S_IDLE;
        endcase
        if (emit_go && !emit_last && step_reg[0])
            state_next = S_DIRV;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            emit_reg      <= 1'b0;
            mode_reg      <= MODE_AXIS;
            width_reg     <= 31'd65536;
            cam_reg[0]    <= '0;
            cam_reg[1]    <= '0;
            cam_reg[2]    <= '0;
            idx_reg       <= '0;
            prev_reg[0]   <= '0;
            prev_reg[1]   <= '0;
            prev_reg[2]   <= '0;
            tex_phase_reg <= 1'b0;
            pass_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                case (cfg.addr)
                    REG_TRAIL_MODE:  mode_reg   <= trail_mode_t'(cfg.wdata[1:0]);
                    REG_STRIP_WIDTH: width_reg  <= cfg.wdata[30:0];
                    REG_CAMERA_X:    cam_reg[0] <= cfg.wdata;
                    REG_CAMERA_Y:    cam_reg[1] <= cfg.wdata;
                    REG_CAMERA_Z:    cam_reg[2] <= cfg.wdata;
                    default:         ;
                endcase
            end

            if (acc)
            begin
                prev_reg[0]   <= pnt.data.pos_x;
                prev_reg[1]   <= pnt.data.pos_y;
                prev_reg[2]   <= pnt.data.pos_z;
                idx_reg       <= short_c ? '0 : ((i_inc >= {1'b0, n_c}) ? '0 : i_inc[CNT_W-1:0]);
                tex_phase_reg <= 1'b1;
                pass_reg      <= 1'b0;
                step_reg      <= '0;
            end

            if (vtx.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_DVW:
                begin
                    if (div_done)
                    begin
                        if (tex_phase_reg)
                        begin
                            tex_phase_reg <= 1'b0;
                            step_reg      <= '0;
                            emit_reg      <= strip_m;
                        end
                        else if (step_reg == 3'd2)
                        begin
                            step_reg <= '0;
                            emit_reg <= 1'b1;
                        end
                        else
                        begin
                            step_reg <= step_reg + 3'd1;
                        end
                    end
                end
                S_DIRV:  step_reg <= '0;
                S_CROSS: step_reg <= (step_reg == 3'd6) ? 3'd0 : step_reg + 3'd1;
                S_SQ:    step_reg <= (step_reg == 3'd3) ? 3'd0 : step_reg + 3'd1;
                S_RTW:
                begin
                    if (rt_done)
                    begin
                        step_reg <= '0;
                        emit_reg <= (root == '0);
                    end
                end
                default: ;
            endcase

            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
                if (emit_last)
                begin
                    emit_reg <= 1'b0;
                    step_reg <= '0;
                end
                else if (step_reg[0])
                begin
                    emit_reg <= 1'b0;
                    pass_reg <= 1'b1;
                    step_reg <= '0;
                end
                else
                begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            i_reg      <= i_c;
            n_reg      <= n_c;
            pos_reg[0] <= pnt.data.pos_x;
            pos_reg[1] <= pnt.data.pos_y;
            pos_reg[2] <= pnt.data.pos_z;
            pr_reg[0]  <= prev_reg[0];
            pr_reg[1]  <= prev_reg[1];
            pr_reg[2]  <= prev_reg[2];
            am_reg[0]  <= mag32(pnt.data.side_x);
            am_reg[1]  <= mag32(pnt.data.side_y);
            am_reg[2]  <= mag32(pnt.data.side_z);
            as_reg     <= {pnt.data.side_z[31], pnt.data.side_y[31], pnt.data.side_x[31]};
            sum_reg    <= '0;
        end

        case (state_reg)
            S_DVW:
            begin
                if (div_done)
                begin
                    if (tex_phase_reg)
                        tv_reg <= quo[TEXV_W-1:0];
                    else
                        off_reg[k] <= quo;
                end
            end
            S_DIRV:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    dm_reg[j] <= mag33({pos_reg[j][31], pos_reg[j]} - {pr_reg[j][31], pr_reg[j]});
                    ds_reg[j] <= ({pos_reg[j][31], pos_reg[j]}
                                  - {pr_reg[j][31], pr_reg[j]}) >> 32 != 33'd0;
                    vm_reg[j] <= mag33({base[j][31], base[j]} - {cam_reg[j][31], cam_reg[j]});
                    vs_reg[j] <= ({base[j][31], base[j]}
                                  - {cam_reg[j][31], cam_reg[j]}) >> 32 != 33'd0;
                    c_reg[j]  <= '0;
                end
            end
            S_SHRD:
            begin
                if (any_d)
                    for (int j = 0; j < 3; j++)
                        dm_reg[j] <= dm_reg[j] >> 1;
            end
            S_SHRV:
            begin
                if (any_v)
                    for (int j = 0; j < 3; j++)
                        vm_reg[j] <= vm_reg[j] >> 1;
            end
            S_CROSS:
            begin
                if (step_reg != 3'd6)
                begin
                    prod_reg <= mul_a * mul_b;
                    psgn_reg <= ds_reg[cd] ^ vs_reg[cv] ^ cneg;
                    pdst_reg <= cdst;
                end
                if (step_reg != 3'd0)
                    c_reg[pdst_reg] <= psgn_reg ? (c_reg[pdst_reg] - $signed(prod_reg[62:0]))
                                                : (c_reg[pdst_reg] + $signed(prod_reg[62:0]));
            end
            S_CMAG:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    cm_reg[j] <= c_reg[j][62] ? (62'd0 - c_reg[j][61:0]) : c_reg[j][61:0];
                    cs_reg[j] <= c_reg[j][62];
                end
            end
            S_SHRC:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (any_c)
                        cm_reg[j] <= cm_reg[j] >> 1;
                    else
                        am_reg[j] <= cm_reg[j][31:0];
                end
                if (!any_c)
                begin
                    as_reg  <= cs_reg;
                    sum_reg <= '0;
                end
            end
            S_SQ:
            begin
                if (step_reg != 3'd3)
                    prod_reg <= mul_a * mul_b;
                if (step_reg != 3'd0)
                    sum_reg <= sum_reg + prod_reg;
            end
            S_RTW:
            begin
                if (rt_done)
                begin
                    len_reg <= root;
                    if (root == '0)
                    begin
                        off_reg[0] <= '0;
                        off_reg[1] <= '0;
                        off_reg[2] <= '0;
                    end
                end
            end
            S_OFFM:
            begin
                prod_reg <= mul_a * mul_b;
            end
            default: ;
        endcase

        if (emit_go)
        begin
            out_reg.vert_x    <= vout[0];
            out_reg.vert_y    <= vout[1];
            out_reg.vert_z    <= vout[2];
            out_reg.tex_u     <= strip_m ? i_reg[0] : step_reg[0];
            out_reg.tex_v     <= bb_first ? '0 : tv_reg;
            out_reg.run_last  <= emit_last;
            out_reg.trail_end <= emit_last && (i_reg == (n_reg - CNT_W'(1)));
        end
    end

    assign vtx.valid = out_valid_reg;
    assign vtx.data  = out_reg;

endmodule

`default_nettype wire

>>> rtl/trv_div.sv
// Restoring divider, one quotient bit per cycle over a 64-bit dividend.
// Stand-alone; used by the top level for texture v and offset divisions.
`default_nettype none

module trv_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [33:0] den,
    output logic             done,
    output logic [31:0]      quo
);
    logic        run_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [33:0] den_reg;
    logic [33:0] rem_reg;
    logic [31:0] quo_reg;
    logic [34:0] rem_sh;
    logic        ge;
    logic [34:0] rem_sub;

    assign rem_sh  = {rem_reg, num_reg[63]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd63;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[62:0], 1'b0};
            rem_reg <= ge ? rem_sub[33:0] : rem_sh[33:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

>>> rtl/trv_isqrt.sv
// Integer square root of a 64-bit value, one result bit per cycle.
// Stand-alone; used by the top level to find an axis length.
`default_nettype none

module trv_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] x,
    output logic             done,
    output logic [31:0]      root
);
    logic        run_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [64:0] rb;
    logic        ge;

    assign rb = {1'b0, r_reg} + {1'b0, bit_reg};
    assign ge = {1'b0, x_reg} >= rb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd31;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                x_reg <= x_reg - rb[63:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

`default_nettype wire
